/* hw/rtl/mst_pkg.sv */
// Shared constants and types for the membership set table.
`timescale 1ns / 1ps

package mst_pkg;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

   typedef struct packed {
      logic active;
      logic hit;
      logic free_seen;
   } chain_type;

endpackage

/* hw/rtl/membership_set_table_top.sv */
// Top level of the membership set table: request control and the row of entry cells.
//
//   channel | direction | transfer fields
//   req     | in        | req_op, req_key
//   rsp     | out       | rsp_found, rsp_status, rsp_count
//
// Between a request's transfer and its result, a scan token walks the cell row
// one entry per cycle, then a finish step applies the change.
// One request is in the table at a time; the next one is taken while a result waits.
// Reset clears all valid marks and the count at once; stored keys are not cleared.
// A stalled result holds the table in its final step until the result is taken.
`timescale 1ns / 1ps

module membership_set_table_top #(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mst_pkg::OP_W-1:0]       req_op,
   input  logic [mst_pkg::KEY_W-1:0]      req_key,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_found,
   output logic [mst_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mst_pkg::COUNT_W-1:0]    rsp_count
);
   import mst_pkg::*;

   localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int CWX = (CW > COUNT_W) ? CW : COUNT_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [KW-1:0]       key_ff;
   logic                insert_ff, delete_ff;
   logic                inject_ff;
   logic                hit_ff, free_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_W-1:0]  rcount_ff;
   logic [CWX-1:0]      count_ext;

   logic                req_fire, can_load, finish, commit;
   chain_type           chain_w [0:CAPACITY];
   logic [CAPACITY-1:0] valid_vec, cand_vec;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == S_FINISH) && can_load;
   assign commit    = finish && insert_ff && !hit_ff && free_ff;

   assign chain_w[0] = '{active: inject_ff, hit: 1'b0, free_seen: 1'b0};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      mst_cell #(
         .KEY_BITS(KW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .key_i   (key_ff),
         .delete_i(delete_ff),
         .commit_i(commit),
         .chain_i (chain_w[i]),
         .chain_o (chain_w[i+1]),
         .valid_o (valid_vec[i]),
         .cand_o  (cand_vec[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (chain_w[CAPACITY].active) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (can_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (commit) begin
         count_in = count_ff + CW'(1);
      end else if (finish && delete_ff && hit_ff) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      status_in = STAT_OK;
      if (insert_ff && !hit_ff && !free_ff) begin
         status_in = STAT_FULL;
      end else if (delete_ff && !hit_ff) begin
         status_in = STAT_ABSENT;
      end
   end

   assign count_ext    = CWX'(count_in);
   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inject_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inject_ff    <= req_fire;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         key_ff    <= req_key[KW-1:0];
         insert_ff <= (req_op == OP_INSERT);
         delete_ff <= (req_op == OP_DELETE);
      end
      if (chain_w[CAPACITY].active) begin
         hit_ff  <= chain_w[CAPACITY].hit;
         free_ff <= chain_w[CAPACITY].free_seen;
      end
      if (finish) begin
         found_ff  <= hit_ff;
         status_ff <= status_in;
         rcount_ff <= count_ext[COUNT_W-1:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = found_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = rcount_ff;

   // The count never runs past the number of entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   // Between requests the count matches the number of valid marks.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (32'(count_ff) == $countones(valid_vec)))
      else $error("entry count disagrees with valid marks");

   // Exactly one cell is chosen when a new key is written.
   assert property (@(posedge clock) disable iff (reset)
      commit |-> $onehot(cand_vec))
      else $error("insert without a single candidate entry");

   // The scan token leaves the row only while a scan is in progress.
   assert property (@(posedge clock) disable iff (reset)
      chain_w[CAPACITY].active |-> (state_ff == S_SCAN))
      else $error("scan token outside of a scan");

   // A full-table report never claims the key was present.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == STAT_FULL)) |-> !found_ff)
      else $error("full status with key found");

endmodule

/* hw/rtl/mst_cell.sv */
// One table entry: stored key, valid mark and a stage of the scan chain.
`timescale 1ns / 1ps

module mst_cell #(
   parameter int KEY_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [KEY_BITS-1:0] key_i,
   input  logic                delete_i,
   input  logic                commit_i,
   input  mst_pkg::chain_type  chain_i,
   output mst_pkg::chain_type  chain_o,
   output logic                valid_o,
   output logic                cand_o
);
   import mst_pkg::*;

   logic [KEY_BITS-1:0] key_ff;
   logic                valid_ff, valid_in;
   logic                cand_ff, cand_in;
   chain_type           chain_ff, chain_in;
   logic                match;

   assign match = valid_ff && (key_ff == key_i);

   always_comb begin
      chain_in = '0;
      cand_in  = cand_ff;
      valid_in = valid_ff;
      if (chain_i.active) begin
         chain_in.active    = 1'b1;
         chain_in.hit       = chain_i.hit | match;
         chain_in.free_seen = chain_i.free_seen | ~valid_ff;
         cand_in            = ~chain_i.free_seen & ~valid_ff;
         if (match && delete_i) begin
            valid_in = 1'b0;
         end
      end
      if (commit_i && cand_ff) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cand_ff  <= 1'b0;
         chain_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         cand_ff  <= cand_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_i && cand_ff) begin
         key_ff <= key_i;
      end
   end

   assign chain_o = chain_ff;
   assign valid_o = valid_ff;
   assign cand_o  = cand_ff;

endmodule

/* tb/mst_checker.sv */
// Checker for the membership set table: predicts each request's result and compares.
`timescale 1ns / 1ps

module mst_checker #(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [mst_pkg::OP_W-1:0]       req_op,
   input  logic [mst_pkg::KEY_W-1:0]      req_key,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_found,
   input  logic [mst_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [mst_pkg::COUNT_W-1:0]    rsp_count,
   output int                             fail_count,
   output int                             pending
);
   import mst_pkg::*;

   localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}}
                                         : ({KEY_W{1'b1}} >> (KEY_W - KEY_BITS));

   typedef struct packed {
      logic                found;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } lookup_result_type;

   logic [KEY_W-1:0]  held_key [CAPACITY];
   bit                held     [CAPACITY];
   int unsigned       held_count;
   lookup_result_type owed_results [$];
   int                errors;

   function automatic lookup_result_type apply_request(logic [OP_W-1:0] op,
                                                       logic [KEY_W-1:0] key);
      int                hit_idx;
      int                free_idx;
      int                i;
      logic [KEY_W-1:0]  k;
      lookup_result_type res;
      k        = key & KEY_MASK;
      hit_idx  = -1;
      free_idx = -1;
      for (i = 0; i < CAPACITY; i++) begin
         if (held[i] && held_key[i] == k && hit_idx < 0) hit_idx = i;
         if (!held[i] && free_idx < 0) free_idx = i;
      end
      res.status = STAT_OK;
      case (op)
         OP_INSERT: begin
            if (hit_idx < 0) begin
               if (free_idx < 0 || held_count >= CAPACITY) begin
                  res.status = STAT_FULL;
               end else begin
                  held_key[free_idx] = k;
                  held[free_idx]     = 1'b1;
                  held_count++;
               end
            end
         end
         OP_DELETE: begin
            if (hit_idx < 0) begin
               res.status = STAT_ABSENT;
            end else begin
               held[hit_idx] = 1'b0;
               if (held_count > 0) held_count--;
            end
         end
         default: begin
         end
      endcase
      res.found = (hit_idx >= 0);
      res.count = COUNT_W'(held_count);
      return res;
   endfunction

   always @(posedge clock) begin
      lookup_result_type exp_res;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) held[i] = 1'b0;
         held_count = 0;
         owed_results.delete();
         errors = 0;
      end else begin
         // The result side is handled first: a result never belongs to a request
         // taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $display("%0t: result transfer with none expected: found=%0d status=%0d count=%0d",
                        $time, rsp_found, rsp_status, rsp_count);
               errors++;
            end else begin
               exp_res = owed_results.pop_front();
               if (rsp_found !== exp_res.found) begin
                  $display("%0t: found mismatch: expected %0d, actual %0d",
                           $time, exp_res.found, rsp_found);
                  errors++;
               end
               if (rsp_status !== exp_res.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, exp_res.status, rsp_status);
                  errors++;
               end
               if (rsp_count !== exp_res.count) begin
                  $display("%0t: count mismatch: expected %0d, actual %0d",
                           $time, exp_res.count, rsp_count);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) owed_results.push_back(apply_request(req_op, req_key));
      end
      fail_count <= errors;
      pending    <= owed_results.size();
   end

endmodule

/* tb/tb_membership_set_table_top.sv */
// Testbench top for the membership set table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_membership_set_table_top;
   import mst_pkg::*;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 32;
   localparam int POOL_SIZE  = 24;
   localparam int RAND_ITEMS = 1030;
   localparam int QUIET_FROM = RAND_ITEMS - 150;
   localparam int LONG_HOLD  = 90;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
   localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [OP_W-1:0]     req_op;
   logic [KEY_W-1:0]    req_key;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_found;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_count;
   int                  fail_count;
   int                  pending;

   bit                  quiet_run;
   bit                  hold_rsp_long;
   logic [KEY_W-1:0]    key_pool [POOL_SIZE];

   membership_set_table_top #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_found  (rsp_found),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   mst_checker #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_found  (rsp_found),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(8_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic offer_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      if (!quiet_run && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic logic [OP_W-1:0] pick_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return OP_INSERT;
      if (roll < 70) return OP_DELETE;
      if (roll < 95) return OP_LOOKUP;
      return OP_SPARE;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp_long) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp_long = 1'b0;
         end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      req_valid     = 1'b0;
      req_op        = OP_INSERT;
      req_key       = '0;
      reset         = 1'b1;
      quiet_run     = 1'b0;
      hold_rsp_long = 1'b0;
      key_pool[0]   = '0;
      key_pool[1]   = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed part: extreme keys, every op, duplicate insert, absent delete,
      // filling the table, insert when full, and reuse of the lowest free entry.
      offer_request(OP_INSERT, key_pool[0]);
      offer_request(OP_INSERT, key_pool[1]);
      offer_request(OP_INSERT, key_pool[0]);
      offer_request(OP_LOOKUP, key_pool[0]);
      offer_request(OP_SPARE, key_pool[1]);
      offer_request(OP_DELETE, 32'h1234_5678);
      offer_request(OP_DELETE, key_pool[1]);
      offer_request(OP_LOOKUP, key_pool[1]);
      for (int i = 2; i < 17; i++) offer_request(OP_INSERT, key_pool[i]);
      offer_request(OP_INSERT, key_pool[20]);
      offer_request(OP_INSERT, key_pool[0]);
      offer_request(OP_DELETE, key_pool[0]);
      offer_request(OP_INSERT, key_pool[20]);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == 300) hold_rsp_long = 1'b1;
         if (n == 600) begin
            req_valid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         if (n == QUIET_FROM) quiet_run = 1'b1;
         offer_request(pick_op(), pick_key());
      end
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (2 * CAPACITY + 8) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
